### sv/first_fit_heap_allocator_assert.svh
// Assertion macros for the first-fit heap allocator.
// Used by the modules that carry concurrent assertions.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FFHA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

### sv/ffha_pkg.sv
// Package for the first-fit heap allocator: request and response types, constants.
// No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
   localparam int unsigned HDR_BYTES = 2;
   localparam int unsigned PERCENT   = 100;
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] alloc_size;
      logic [6:0] release_offset;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [6:0] data_offset;
      logic [7:0] used_bytes;
      logic [6:0] fragmentation;
   } rsp_type;
endpackage

### sv/ffha_divider.sv
// Restoring divider, one quotient bit per cycle, for the fragmentation score.
// Depends on nothing.
`timescale 1ns / 1ps
module ffha_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [7:0]  divisor,
   output logic        done,
   output logic [15:0] quotient
);
   logic [15:0] q_ff, q_in;
   logic [7:0]  r_ff, r_in;
   logic [7:0]  d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [8:0]  trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[15]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = 8'(trial - {1'b0, d_ff});
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = trial[7:0];
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = busy_ff && (cnt_ff == 5'd1) && !start;
   assign quotient = q_in;
endmodule

### sv/first_fit_heap_allocator.sv
// Steps: accept, then the allocate walk (read each block's link and size, then write the new
// block's link and size and relink its predecessor) or the free walk (follow the links, then
// copy the target's link into its predecessor), the usage walk, the fragmentation walk (a
// serial divide per block) and the response.
// Throughput: one request at a time; the next is taken after the response is taken.
// Reset: synchronous; the fixed header is written in S_INIT0 and S_INIT1 after reset, no request
// is taken then. Other bytes undefined.
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_assert.svh"
module first_fit_heap_allocator #(
   parameter int unsigned STORE_BYTES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffha_pkg::rsp_type rsp_data
);
   localparam int unsigned AW = $clog2(STORE_BYTES);
   localparam logic [8:0] SB = 9'(STORE_BYTES);
   localparam logic [12:0] RECIP_100 = 13'd5243;

   typedef enum logic [4:0] {
      S_INIT0, S_INIT1, S_IDLE,
      S_ARD0, S_ARD1, S_ACHK, S_AW0, S_AW1, S_AW2,
      S_FRD, S_FCHK, S_FTR, S_FTW,
      S_URD0, S_URD1, S_UACC,
      S_GRD0, S_GRD1, S_GACC, S_GDIV, S_GSQ, S_GSQD,
      S_RSP
   } state_type;

   state_type state_ff;
   logic [7:0] mem [STORE_BYTES];
   logic [7:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic rd_en;
   logic we;
   logic [AW-1:0] waddr;
   logic [7:0] wdata;

   ffha_pkg::req_type req_ff;
   logic [8:0] p_ff;
   logic [8:0] nxt_ff;
   logic [8:0] steps_ff;
   logic [8:0] end_ff;
   logic [8:0] used_ff;
   logic [6:0] frag_ff;
   logic [6:0] f_ff;
   logic [8:0] gap_ff;
   logic ok_ff;
   logic [6:0] doff_ff;
   ffha_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic div_start;
   logic div_done;
   logic [15:0] div_q;
   logic [15:0] div_num;
   logic [7:0]  div_den;

   logic [8:0] end_c;
   logic [8:0] need;
   logic [8:0] tgt;
   logic [13:0] sq;
   logic [25:0] sq_scaled;
   logic [6:0] sq_pct;

   ffha_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_num), .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   assign end_c = p_ff + 9'd2 + {1'b0, rdata_ff};
   assign need = {1'b0, req_ff.alloc_size} + 9'd2;
   assign tgt = {1'b0, 8'({1'b0, req_ff.release_offset} - 8'd2)};
   assign sq = 14'(f_ff) * 14'(f_ff);
   assign sq_scaled = 26'(sq) * 26'(RECIP_100);
   assign sq_pct = sq_scaled[25:19];

   always_comb begin
      raddr = '0;
      rd_en = 1'b0;
      we = 1'b0;
      waddr = '0;
      wdata = '0;
      div_start = 1'b0;
      div_num = '0;
      div_den = 8'(SB - used_ff);
      unique case (state_ff)
         S_INIT0: begin we = 1'b1; waddr = '0; wdata = 8'(STORE_BYTES); end
         S_INIT1: begin we = 1'b1; waddr = AW'(1); wdata = '0; end
         S_ARD0, S_FRD, S_URD0, S_GRD0: begin rd_en = 1'b1; raddr = p_ff[AW-1:0]; end
         S_ARD1, S_URD1, S_GRD1: begin rd_en = 1'b1; raddr = AW'(p_ff + 9'd1); end
         S_AW0: begin we = 1'b1; waddr = end_ff[AW-1:0]; wdata = nxt_ff[7:0]; end
         S_AW1: begin we = 1'b1; waddr = AW'(end_ff + 9'd1); wdata = req_ff.alloc_size; end
         S_AW2: begin we = 1'b1; waddr = p_ff[AW-1:0]; wdata = end_ff[7:0]; end
         S_FTR: begin rd_en = 1'b1; raddr = tgt[AW-1:0]; end
         S_FTW: begin we = 1'b1; waddr = p_ff[AW-1:0]; wdata = rdata_ff; end
         S_GDIV: begin
            div_start = 1'b1;
            div_num = 16'(gap_ff * 16'(ffha_pkg::PERCENT));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (rd_en) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_INIT0: state_ff <= S_INIT1;
            S_INIT1: state_ff <= S_IDLE;
            S_IDLE: if (req_valid) begin
               req_ff <= req_data;
               p_ff <= '0;
               steps_ff <= '0;
               ok_ff <= 1'b0;
               doff_ff <= '0;
               state_ff <= (req_data.func == ffha_pkg::FUNC_ALLOC) ? S_ARD0 : S_FRD;
            end
            S_ARD0: state_ff <= S_ARD1;
            S_ARD1: begin nxt_ff <= {1'b0, rdata_ff}; state_ff <= S_ACHK; end
            S_ACHK: begin
               end_ff <= end_c;
               if (nxt_ff >= end_c && (nxt_ff - end_c) >= need) begin
                  state_ff <= S_AW0;
               end else if (nxt_ff + 9'd1 < SB && steps_ff + 9'd1 <= SB) begin
                  p_ff <= nxt_ff;
                  steps_ff <= steps_ff + 9'd1;
                  state_ff <= S_ARD0;
               end else begin
                  p_ff <= '0; steps_ff <= '0; used_ff <= '0;
                  state_ff <= S_URD0;
               end
            end
            S_AW0: state_ff <= S_AW1;
            S_AW1: state_ff <= S_AW2;
            S_AW2: begin
               ok_ff <= 1'b1;
               doff_ff <= 7'(end_ff + 9'd2);
               p_ff <= '0; steps_ff <= '0; used_ff <= '0;
               state_ff <= S_URD0;
            end
            S_FRD: state_ff <= S_FCHK;
            S_FCHK: begin
               if ({1'b0, rdata_ff} == tgt && tgt + 9'd1 < SB) begin
                  state_ff <= S_FTR;
               end else if ({1'b0, rdata_ff} + 9'd1 < SB && steps_ff + 9'd1 <= SB) begin
                  p_ff <= {1'b0, rdata_ff};
                  steps_ff <= steps_ff + 9'd1;
                  state_ff <= S_FRD;
               end else begin
                  p_ff <= '0; steps_ff <= '0; used_ff <= '0;
                  state_ff <= S_URD0;
               end
            end
            S_FTR: state_ff <= S_FTW;
            S_FTW: begin
               ok_ff <= 1'b1;
               p_ff <= '0; steps_ff <= '0; used_ff <= '0;
               state_ff <= S_URD0;
            end
            S_URD0: state_ff <= S_URD1;
            S_URD1: begin nxt_ff <= {1'b0, rdata_ff}; state_ff <= S_UACC; end
            S_UACC: begin
               used_ff <= used_ff + 9'd2 + {1'b0, rdata_ff};
               if (nxt_ff + 9'd1 < SB && steps_ff < SB) begin
                  p_ff <= nxt_ff; steps_ff <= steps_ff + 9'd1; state_ff <= S_URD0;
               end else begin
                  frag_ff <= 7'(ffha_pkg::PERCENT);
                  p_ff <= '0; steps_ff <= '0;
                  state_ff <= S_GRD0;
               end
            end
            S_GRD0: begin
               if (used_ff >= SB) begin
                  frag_ff <= '0; state_ff <= S_RSP;
               end else state_ff <= S_GRD1;
            end
            S_GRD1: begin nxt_ff <= {1'b0, rdata_ff}; state_ff <= S_GACC; end
            S_GACC: begin
               gap_ff <= (nxt_ff > end_c) ? nxt_ff - end_c : 9'd0;
               state_ff <= S_GDIV;
            end
            S_GDIV: state_ff <= S_GSQ;
            S_GSQ: if (div_done) begin f_ff <= 7'(div_q); state_ff <= S_GSQD; end
            S_GSQD: begin
               frag_ff <= (frag_ff > sq_pct) ? frag_ff - sq_pct : 7'd0;
               if (nxt_ff + 9'd1 < SB && steps_ff + 9'd1 < SB) begin
                  p_ff <= nxt_ff; steps_ff <= steps_ff + 9'd1; state_ff <= S_GRD0;
               end else state_ff <= S_RSP;
            end
            S_RSP: if (!rsp_valid_ff) begin
               rsp_ff.status <= !ok_ff;
               rsp_ff.data_offset <= ok_ff ? doff_ff : 7'd0;
               rsp_ff.used_bytes <= used_ff[7:0];
               rsp_ff.fragmentation <= frag_ff;
               rsp_valid_ff <= 1'b1;
            end else if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `FFHA_ASSERT_IMPL(a_rsp_only_in_rsp, clock, reset, rsp_valid_ff, state_ff == S_RSP, "rsp")
   `FFHA_ASSERT_IMPL(a_no_accept_busy, clock, reset, req_ready, !rsp_valid_ff, "ready")
   `FFHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff, "drop")
endmodule

### bench/tb_first_fit_heap_allocator.sv
// Self-checking testbench for first_fit_heap_allocator: directed and random
// allocate/free requests, with a byte-level heap predictor and an in-order response checker.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;

   localparam int STORE     = 128;
   localparam int WDOG_MAX  = 100000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   ffha_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   ffha_pkg::rsp_type rsp_data;

   first_fit_heap_allocator #(.STORE_BYTES(STORE)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   logic [7:0] heap_bytes [0:STORE-1];
   ffha_pkg::rsp_type pending_rsp [$];
   int         live_offsets [$];
   bit         quiet = 1'b0;
   int         errors = 0;
   int         n_req = 0, n_rsp = 0, n_alloc_ok = 0, n_free_ok = 0, n_fail = 0;
   int         n_full = 0;
   int         wdog = 0;

   function automatic void heap_clear();
      foreach (heap_bytes[i]) heap_bytes[i] = 8'd0;
      heap_bytes[0] = STORE[7:0];
   endfunction

   function automatic int chain_used();
      int used, p, steps;
      used = 2; p = heap_bytes[0]; steps = 0;
      while (p + 1 < STORE && steps < STORE) begin
         used += 2 + heap_bytes[p+1];
         p = heap_bytes[p];
         steps++;
      end
      return used;
   endfunction

   function automatic int chain_frag(int used);
      int free_room, frag, p, steps, nxt, e, gap, f, sq;
      if (used >= STORE) return 0;
      free_room = STORE - used; frag = 100; p = 0; steps = 0;
      while (p + 1 < STORE && steps < STORE) begin
         nxt = heap_bytes[p];
         e = p + 2 + heap_bytes[p+1];
         gap = nxt > e ? nxt - e : 0;
         f = gap * 100 / free_room;
         sq = f * f / 100;
         frag = frag > sq ? frag - sq : 0;
         p = nxt;
         steps++;
      end
      return frag;
   endfunction

   function automatic ffha_pkg::rsp_type heap_apply(ffha_pkg::req_type r, output int new_off);
      ffha_pkg::rsp_type res;
      int p, steps, nxt, e, target, used;
      bit ok;
      ok = 1'b0; new_off = 0; p = 0; steps = 0;
      if (r.func == ffha_pkg::FUNC_ALLOC) begin
         while (!ok && p + 1 < STORE && steps <= STORE) begin
            nxt = heap_bytes[p];
            e = p + 2 + heap_bytes[p+1];
            if (nxt >= e && nxt - e >= int'(r.alloc_size) + 2) begin
               heap_bytes[e]   = nxt[7:0];
               heap_bytes[e+1] = r.alloc_size;
               heap_bytes[p]   = e[7:0];
               new_off = e + 2;
               ok = 1'b1;
            end else begin
               p = nxt;
               steps++;
            end
         end
      end else begin
         target = (int'(r.release_offset) - 2) & 255;
         while (!ok && p + 1 < STORE && steps <= STORE) begin
            nxt = heap_bytes[p];
            if (nxt == target && target + 1 < STORE) begin
               heap_bytes[p] = heap_bytes[target];
               ok = 1'b1;
            end else begin
               p = nxt;
               steps++;
            end
         end
      end
      used = chain_used();
      res.status        = ~ok;
      res.data_offset   = new_off[6:0];
      res.used_bytes    = used[7:0];
      res.fragmentation = 7'(chain_frag(used));
      return res;
   endfunction

   task automatic send_request(ffha_pkg::req_type r);
      ffha_pkg::rsp_type res;
      int off;
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      res = heap_apply(r, off);
      pending_rsp.push_back(res);
      n_req++;
      if (res.status) n_fail++;
      else if (r.func == ffha_pkg::FUNC_ALLOC) begin
         n_alloc_ok++;
         if (off < STORE) live_offsets.push_back(off);
      end else begin
         n_free_ok++;
         foreach (live_offsets[i])
            if (live_offsets[i] == r.release_offset) begin
               live_offsets.delete(i);
               break;
            end
      end
      if (res.used_bytes == STORE) n_full++;
   endtask

   task automatic send_alloc(int size);
      ffha_pkg::req_type r;
      r.func = ffha_pkg::FUNC_ALLOC; r.alloc_size = size[7:0];
      r.release_offset = 7'($urandom_range(127));
      send_request(r);
   endtask

   task automatic send_free(int off);
      ffha_pkg::req_type r;
      r.func = ffha_pkg::FUNC_FREE; r.alloc_size = 8'($urandom_range(255));
      r.release_offset = off[6:0];
      send_request(r);
   endtask

   task automatic release_all();
      int k;
      for (k = 0; k < STORE && live_offsets.size() > 0; k++) send_free(live_offsets[0]);
   endtask

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) wdog <= 0;
         else wdog <= wdog + 1;
         if (wdog > WDOG_MAX) begin
            $display("%0t: watchdog expired, %0d responses outstanding",
                     $realtime, pending_rsp.size());
            $display("** first_fit_heap_allocator: FAILED **");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response %p", $realtime, rsp_data);
            end else begin
               if (rsp_data.status !== pending_rsp[0].status) begin
                  errors++;
                  $display("%0t: status exp %0d got %0d", $realtime,
                           pending_rsp[0].status, rsp_data.status);
               end
               if (rsp_data.data_offset !== pending_rsp[0].data_offset) begin
                  errors++;
                  $display("%0t: data_offset exp %0d got %0d", $realtime,
                           pending_rsp[0].data_offset, rsp_data.data_offset);
               end
               if (rsp_data.used_bytes !== pending_rsp[0].used_bytes) begin
                  errors++;
                  $display("%0t: used_bytes exp %0d got %0d", $realtime,
                           pending_rsp[0].used_bytes, rsp_data.used_bytes);
               end
               if (rsp_data.fragmentation !== pending_rsp[0].fragmentation) begin
                  errors++;
                  $display("%0t: fragmentation exp %0d got %0d", $realtime,
                           pending_rsp[0].fragmentation, rsp_data.fragmentation);
               end
               void'(pending_rsp.pop_front());
            end
         end
      end
   end

   task automatic test_directed();
      send_alloc(255);
      send_alloc(127);
      send_alloc(0);
      send_free(0);
      send_free(1);
      send_free(2);
      send_free(127);
      send_free(4);
      send_free(4);
      send_alloc(124);
      send_alloc(0);
      send_free(4);
      send_alloc(122);
      send_alloc(0);
      send_free(0);
      send_free(4);
      send_alloc(10);
      send_alloc(20);
      send_alloc(5);
      send_free(16);
      send_alloc(3);
      send_alloc(90);
      release_all();
   endtask

   task automatic test_random(int count);
      int k;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(19))
            0:       send_alloc($urandom_range(255));
            1:       send_free($urandom_range(127));
            2, 3:    send_alloc($urandom_range(60));
            4:       if (live_offsets.size() > 0) release_all();
                     else send_alloc($urandom_range(8));
            default: begin
               if (live_offsets.size() > 0 && $urandom_range(1))
                  send_free(live_offsets[$urandom_range(live_offsets.size() - 1)]);
               else
                  send_alloc($urandom_range(24));
            end
         endcase
      end
   endtask

   task automatic test_fill_drain();
      int k, n;
      quiet = 1'b1;
      for (k = 0; k < 4; k++) begin
         for (n = 0; n < STORE && chain_used() < STORE - 2; n++)
            send_alloc($urandom_range(6));
         send_alloc(0);
         send_alloc(0);
         release_all();
      end
      quiet = 1'b0;
   endtask

   initial begin
      heap_clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(800);
      test_fill_drain();
      test_random(750);
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Ran %0d requests: %0d allocations and %0d frees succeeded, %0d refused.",
               n_req, n_alloc_ok, n_free_ok, n_fail);
      $display("Heap was completely full on %0d responses; %0d responses checked.",
               n_full, n_rsp);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("** first_fit_heap_allocator: PASSED **");
      end else begin
         $display("** first_fit_heap_allocator: FAILED **");
      end
      $finish;
   end
endmodule

### files.f
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_divider.sv
sv/first_fit_heap_allocator.sv
bench/tb_first_fit_heap_allocator.sv
